>>> rtl/scl_pkg.sv
`timescale 1ns / 1ps

package scl_pkg;

  localparam int MAX_ARGS = 10;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_PLUS     = 8'd43;
  localparam logic [7:0] CH_MINUS    = 8'd45;
  localparam logic [7:0] CH_ZERO     = 8'd48;
  localparam logic [7:0] CH_NINE     = 8'd57;
  localparam logic [7:0] CH_QUESTION = 8'd63;

  localparam logic [1:0] KIND_CODE = 2'd0;
  localparam logic [1:0] KIND_ARG  = 2'd1;
  localparam logic [1:0] KIND_EOL  = 2'd2;

  localparam logic [2:0] OP_CODE  = 3'd0;
  localparam logic [2:0] OP_SIGN  = 3'd1;
  localparam logic [2:0] OP_DIGIT = 3'd2;
  localparam logic [2:0] OP_CLOSE = 3'd3;
  localparam logic [2:0] OP_END   = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       close;
    logic       req;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         code_char;
    logic signed [15:0] arg_value;
    logic [3:0]         arg_position;
    logic               is_request;
    logic [4:0]         arg_count;
    logic               args_overflowed;
    logic               last;
  } res_t;

endpackage

>>> rtl/scl_if.sv
`timescale 1ns / 1ps

interface scl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scl_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         code_char;
  logic signed [15:0] arg_value;
  logic [3:0]         arg_position;
  logic               is_request;
  logic [4:0]         arg_count;
  logic               args_overflowed;
  logic               last;

  modport source (output valid, output kind, output code_char, output arg_value,
                  output arg_position, output is_request, output arg_count,
                  output args_overflowed, output last, input ready);
  modport sink (input valid, input kind, input code_char, input arg_value,
                input arg_position, input is_request, input arg_count,
                input args_overflowed, input last, output ready);
endinterface

>>> rtl/scl_front.sv
`timescale 1ns / 1ps

module scl_front (
  input  logic          clk,
  input  logic          rst_n,
  scl_byte_if.sink      in_ch,
  input  logic          q_full,
  output logic          q_push,
  output scl_pkg::cmd_t q_data
);
  import scl_pkg::*;

  logic line_empty_r, line_empty_nxt;
  logic request_r, request_nxt;
  logic in_args_r, in_args_nxt;
  logic tok_nonempty_r, tok_nonempty_nxt;
  logic tok_stopped_r, tok_stopped_nxt;
  logic accept;
  logic [7:0] c;
  logic is_ws;
  logic is_digit;
  logic is_sign;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign c           = in_ch.rx_byte;
  assign is_ws       = (c inside {[CH_TAB:CH_CR], CH_SPACE});
  assign is_digit    = (c inside {[CH_ZERO:CH_NINE]});
  assign is_sign     = (c == CH_PLUS) || (c == CH_MINUS);

  always_comb begin
    line_empty_nxt   = line_empty_r;
    request_nxt      = request_r;
    in_args_nxt      = in_args_r;
    tok_nonempty_nxt = tok_nonempty_r;
    tok_stopped_nxt  = tok_stopped_r;
    q_push           = 1'b0;
    q_data           = '0;
    if (accept) begin
      if (c == CH_NEWLINE) begin
        if (!line_empty_r) begin
          q_push           = 1'b1;
          q_data.op        = OP_END;
          q_data.close     = in_args_r && tok_nonempty_r;
          q_data.req       = request_r;
          line_empty_nxt   = 1'b1;
          request_nxt      = 1'b0;
          in_args_nxt      = 1'b0;
          tok_nonempty_nxt = 1'b0;
          tok_stopped_nxt  = 1'b0;
        end
      end else if (line_empty_r && c == CH_QUESTION) begin
        line_empty_nxt = 1'b0;
        request_nxt    = 1'b1;
      end else begin
        line_empty_nxt = 1'b0;
        if (is_ws) begin
          if (!in_args_r) begin
            in_args_nxt = 1'b1;
          end else begin
            q_push           = 1'b1;
            q_data.op        = OP_CLOSE;
            tok_nonempty_nxt = 1'b0;
            tok_stopped_nxt  = 1'b0;
          end
        end else if (in_args_r) begin
          if (!tok_nonempty_r && is_sign) begin
            q_push      = 1'b1;
            q_data.op   = OP_SIGN;
            q_data.data = {7'd0, c == CH_MINUS};
          end else if (!tok_stopped_r && is_digit) begin
            q_push      = 1'b1;
            q_data.op   = OP_DIGIT;
            q_data.data = c - CH_ZERO;
          end else begin
            tok_stopped_nxt = 1'b1;
          end
          tok_nonempty_nxt = 1'b1;
        end else begin
          q_push      = 1'b1;
          q_data.op   = OP_CODE;
          q_data.data = c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_empty_r   <= 1'b1;
      request_r      <= 1'b0;
      in_args_r      <= 1'b0;
      tok_nonempty_r <= 1'b0;
      tok_stopped_r  <= 1'b0;
    end else begin
      line_empty_r   <= line_empty_nxt;
      request_r      <= request_nxt;
      in_args_r      <= in_args_nxt;
      tok_nonempty_r <= tok_nonempty_nxt;
      tok_stopped_r  <= tok_stopped_nxt;
    end
  end

endmodule

>>> rtl/scl_queue.sv
`timescale 1ns / 1ps

module scl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  scl_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output scl_pkg::cmd_t head
);
  import scl_pkg::*;

  cmd_t            q_mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;

  assign full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

endmodule

>>> rtl/scl_back.sv
`timescale 1ns / 1ps

module scl_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  scl_pkg::cmd_t head,
  output logic          q_pop,
  scl_result_if.source  out_ch
);
  import scl_pkg::*;

  logic [15:0] accum_r, accum_nxt;
  logic        neg_r, neg_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic        phase_r, phase_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        res_r, res_nxt;
  logic        room;
  logic        produces;
  logic        can_load;
  logic        go;
  logic [15:0] tok_value;

  assign room      = (cnt_r < 5'(MAX_ARGS));
  assign can_load  = !out_valid_r || out_ch.ready;
  assign produces  = (head.op == OP_CODE) || (head.op == OP_END)
                     || (head.op == OP_CLOSE && room);
  assign go        = !q_empty && (can_load || !produces);
  assign tok_value = neg_r ? 16'(16'd0 - accum_r) : accum_r;

  always_comb begin
    accum_nxt     = accum_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    if (go) begin
      q_pop   = 1'b1;
      if (produces) begin
        res_nxt = '0;
      end
      case (head.op)
        OP_CODE: begin
          out_valid_nxt     = 1'b1;
          res_nxt.kind      = KIND_CODE;
          res_nxt.code_char = head.data;
          res_nxt.last      = 1'b1;
        end
        OP_SIGN: begin
          neg_nxt = head.data[0];
        end
        OP_DIGIT: begin
          accum_nxt = (accum_r << 3) + (accum_r << 1) + {12'd0, head.data[3:0]};
        end
        OP_CLOSE: begin
          if (room) begin
            out_valid_nxt        = 1'b1;
            res_nxt.kind         = KIND_ARG;
            res_nxt.arg_value    = $signed(tok_value);
            res_nxt.arg_position = cnt_r[3:0];
            res_nxt.last         = 1'b1;
            cnt_nxt              = cnt_r + 5'd1;
          end else begin
            ovf_nxt = 1'b1;
          end
          accum_nxt = '0;
          neg_nxt   = 1'b0;
        end
        OP_END: begin
          if (head.close && !phase_r && room) begin
            q_pop                = 1'b0;
            phase_nxt            = 1'b1;
            out_valid_nxt        = 1'b1;
            res_nxt.kind         = KIND_ARG;
            res_nxt.arg_value    = $signed(tok_value);
            res_nxt.arg_position = cnt_r[3:0];
            cnt_nxt              = cnt_r + 5'd1;
            accum_nxt            = '0;
            neg_nxt              = 1'b0;
          end else begin
            out_valid_nxt           = 1'b1;
            res_nxt.kind            = KIND_EOL;
            res_nxt.is_request      = head.req;
            res_nxt.arg_count       = cnt_r;
            res_nxt.args_overflowed = ovf_r || (head.close && !phase_r);
            res_nxt.last            = 1'b1;
            cnt_nxt                 = '0;
            ovf_nxt                 = 1'b0;
            accum_nxt               = '0;
            neg_nxt                 = 1'b0;
            phase_nxt               = 1'b0;
          end
        end
        default: begin
          res_nxt = res_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      neg_r       <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      accum_r     <= accum_nxt;
      neg_r       <= neg_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = res_r.kind;
  assign out_ch.code_char       = res_r.code_char;
  assign out_ch.arg_value       = res_r.arg_value;
  assign out_ch.arg_position    = res_r.arg_position;
  assign out_ch.is_request      = res_r.is_request;
  assign out_ch.arg_count       = res_r.arg_count;
  assign out_ch.args_overflowed = res_r.args_overflowed;
  assign out_ch.last            = res_r.last;

endmodule

>>> rtl/serial_command_line_parser.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// in_ch     sink       rx_byte
// out_ch    source     kind, code_char, arg_value, arg_position, is_request,
//                      arg_count, args_overflowed, last
//
// One byte accepted per cycle while the four-entry command queue has room.
// Each queued command is handled in turn by the back end; a line feed that closes
// a pending argument while fewer than MAX_ARGS are stored yields an argument
// result, then an end-of-line result.
// Results leave from a single output register; a stall there backs up the queue.
// rst_n is synchronous, active low, and returns the parser to line start.

module serial_command_line_parser (
  input  logic         clk,
  input  logic         rst_n,
  scl_byte_if.sink     in_ch,
  scl_result_if.source out_ch
);
  import scl_pkg::*;

  logic q_push;
  cmd_t q_wdata;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_head;

  scl_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  scl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  scl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
